>>> hdl/lzr_pkg.sv
// ----------------------------------------------------------------------------
// lzr_pkg
// shared types, widths and the lanczos-3 weight table for the resizer
// ----------------------------------------------------------------------------
package lzr_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;
  localparam logic [1:0] REG_INV_SCALE  = 2'd3;

  // reset values of the registers
  localparam logic [8:0]  RST_SRC_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_SRC_HEIGHT = 9'd256;
  localparam logic [14:0] RST_SCALE      = 15'd4096;
  localparam logic [14:0] RST_INV_SCALE  = 15'd4096;

  // scale limits, q3.12
  localparam logic [14:0] SCALE_MIN = 15'd1024;
  localparam logic [14:0] SCALE_MAX = 15'd16384;
  localparam logic [14:0] SCALE_ONE = 15'd4096;

  // datapath widths
  localparam int PW   = 14;  // source position along one axis
  localparam int TW   = 30;  // centre and tap terms, 1/8192 pixel
  localparam int WTW  = 18;  // signed q1.14 tap weight
  localparam int COLW = 36;  // signed channel sum
  localparam int TOTW = 26;  // signed weight total

  // bin value that stands for "three or more", weight zero
  localparam logic [2:0] BIN_FAR = 3'd6;

  typedef struct packed {
    logic [8:0]  src_width;
    logic [8:0]  src_height;
    logic [14:0] scale;
    logic [14:0] inv_scale;
  } cfg_t;

  // one queued beat, already classified by the front part
  typedef struct packed {
    logic        is_load;
    logic        load_ok;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] pix;
  } fe_item_t;

  // tap weight from two half-step bins, product of the 1-d lobe values
  // rounded half away from zero back to q1.14
  function automatic logic signed [WTW-1:0] tap_weight(input logic [2:0] bx,
                                                       input logic [2:0] by);
    logic [1:0] cx;
    logic [1:0] cy;
    logic       zx;
    logic       zy;
    logic signed [WTW-1:0] w;
    cx = 2'd0;
    cy = 2'd0;
    zx = 1'b0;
    zy = 1'b0;
    case (bx)
      3'd0: cx = 2'd0;
      3'd1: cx = 2'd1;
      3'd3: cx = 2'd2;
      3'd5: cx = 2'd3;
      default: zx = 1'b1;
    endcase
    case (by)
      3'd0: cy = 2'd0;
      3'd1: cy = 2'd1;
      3'd3: cy = 2'd2;
      3'd5: cy = 2'd3;
      default: zy = 1'b1;
    endcase
    case ({cx, cy})
      4'h0: w = 18'sd16384;
      4'h1: w = 18'sd9960;
      4'h2: w = -18'sd2213;
      4'h3: w = 18'sd398;
      4'h4: w = 18'sd9960;
      4'h5: w = 18'sd6055;
      4'h6: w = -18'sd1345;
      4'h7: w = 18'sd242;
      4'h8: w = -18'sd2213;
      4'h9: w = -18'sd1345;
      4'ha: w = 18'sd299;
      4'hb: w = -18'sd54;
      4'hc: w = 18'sd398;
      4'hd: w = 18'sd242;
      4'he: w = -18'sd54;
      4'hf: w = 18'sd10;
      default: w = '0;
    endcase
    return (zx || zy) ? '0 : w;
  endfunction

endpackage

>>> hdl/lzr_ram.sv
// ----------------------------------------------------------------------------
// lzr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lzr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lzr_front.sv
// ----------------------------------------------------------------------------
// lzr_front
// input side: takes beats, classifies loads and requests, two-entry queue
// ----------------------------------------------------------------------------
module lzr_front import lzr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic [9:0] coord_x,
  input  logic [9:0] coord_y,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  output logic       q_valid,
  output fe_item_t   q_item,
  input  logic       q_take
);

  fe_item_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  fe_item_t   item_in;

  // classify the incoming beat
  always_comb begin
    item_in.is_load = !kind;
    item_in.load_ok = ({3'b0, coord_x} < 13'(MAX_WIDTH)) &&
                      ({3'b0, coord_y} < 13'(MAX_HEIGHT));
    item_in.x       = coord_x;
    item_in.y       = coord_y;
    item_in.pix     = {alpha_in, blue_in, green_in, red_in};
  end

  assign full    = (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = entry[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      entry[wr_ptr] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_take);
    end
  end

endmodule

>>> hdl/lzr_back.sv
// ----------------------------------------------------------------------------
// lzr_back
// execution side: frame store writes, window walk, weighting and division
// ----------------------------------------------------------------------------
module lzr_back import lzr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  fe_item_t      q_item,
  output logic          q_take,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [31:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [31:0]   mem_rdata,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    red_out,
  output logic [7:0]    green_out,
  output logic [7:0]    blue_out,
  output logic [7:0]    alpha_out,
  output logic          out_of_range
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SETUP    = 8'b0000_0010,
    ST_WIN      = 8'b0000_0100,
    ST_TAP_A    = 8'b0000_1000,
    ST_TAP_B    = 8'b0001_0000,
    ST_TAP_C    = 8'b0010_0000,
    ST_DIV_INIT = 8'b0100_0000,
    ST_DIV_STEP = 8'b1000_0000
  } state_t;

  state_t state;

  // saturated configuration
  logic [PW-1:0] sw;
  logic [PW-1:0] sh;
  logic [14:0]   sf;
  logic [14:0]   inv;
  logic          up_c;

  always_comb begin
    sw   = (cfg.src_width == 9'd0) ? PW'(1) :
           ({5'b0, cfg.src_width} > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) :
           {5'b0, cfg.src_width};
    sh   = (cfg.src_height == 9'd0) ? PW'(1) :
           ({5'b0, cfg.src_height} > PW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) :
           {5'b0, cfg.src_height};
    sf   = (cfg.scale < SCALE_MIN) ? SCALE_MIN :
           (cfg.scale > SCALE_MAX) ? SCALE_MAX : cfg.scale;
    inv  = (cfg.inv_scale < SCALE_MIN) ? SCALE_MIN :
           (cfg.inv_scale > SCALE_MAX) ? SCALE_MAX : cfg.inv_scale;
    up_c = (sf > SCALE_ONE);
  end

  // request registers
  logic [9:0]    req_x;
  logic [9:0]    req_y;
  logic          up;
  logic [28:0]   dw_p;
  logic [28:0]   dh_p;
  logic [TW-1:0] c_x;
  logic [TW-1:0] c_y;
  logic [TW-1:0] m1_x;
  logic [TW-1:0] m1_y;
  logic [TW-1:0] m2_x;
  logic [TW-1:0] m2_y;
  logic [TW-1:0] ot_x;
  logic [TW-1:0] ot_y;
  logic [PW-1:0] lo_x;
  logic [PW-1:0] hi_x;
  logic [PW-1:0] hi_y;
  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic [TW-1:0] pt_x;
  logic [TW-1:0] pt_y;
  logic [2:0]    bin_x;
  logic [2:0]    bin_y;
  logic [31:0]   pix;
  logic signed [COLW-1:0] col [4];
  logic signed [TOTW-1:0] total;
  logic [1:0]    ch;
  logic [2:0]    step;
  logic [COLW-1:0] rem;
  logic [7:0]    quo;
  logic [7:0]    chan_q [4];
  logic          res_valid;
  logic          res_oor;

  // odd half-pixel term 2*o+1
  function automatic logic [10:0] ox2_r(input logic [9:0] o);
    return {o, 1'b1};
  endfunction

  // centre terms of the request coordinates
  logic [10:0] ox2;
  logic [10:0] oy2;
  logic [11:0] ox7;
  logic [11:0] oy7;
  logic [10:0] ox5;
  logic [10:0] oy5;

  always_comb begin
    ox2 = {q_item.x, 1'b1};
    oy2 = {q_item.y, 1'b1};
    ox7 = {1'b0, q_item.x, 1'b0} + 12'd7;
    oy7 = {1'b0, q_item.y, 1'b0} + 12'd7;
    ox5 = ({q_item.x, 1'b0} > 11'd5) ? ({q_item.x, 1'b0} - 11'd5) : 11'd0;
    oy5 = ({q_item.y, 1'b0} > 11'd5) ? ({q_item.y, 1'b0} - 11'd5) : 11'd0;
  end

  // window bounds
  logic [PW-1:0] a_x;
  logic [PW-1:0] a_y;
  logic [PW-1:0] b_x;
  logic [PW-1:0] b_y;
  logic [PW-1:0] bc_x;
  logic [PW-1:0] bc_y;
  logic          oor_c;

  always_comb begin
    if (up) begin
      a_x = (c_x >= TW'(24576)) ? PW'((c_x - TW'(24576)) >> 13) : '0;
      a_y = (c_y >= TW'(24576)) ? PW'((c_y - TW'(24576)) >> 13) : '0;
      b_x = PW'((c_x + TW'(24576)) >> 13);
      b_y = PW'((c_y + TW'(24576)) >> 13);
    end else begin
      a_x = PW'(m1_x >> 13);
      a_y = PW'(m1_y >> 13);
      b_x = PW'(m2_x >> 13);
      b_y = PW'(m2_y >> 13);
    end
    bc_x  = (b_x > sw - PW'(1)) ? sw - PW'(1) : b_x;
    bc_y  = (b_y > sh - PW'(1)) ? sh - PW'(1) : b_y;
    oor_c = ({7'b0, req_x} >= dw_p[28:12]) || ({7'b0, req_y} >= dh_p[28:12]);
  end

  // tap distance bins
  logic signed [TW:0] dx_s;
  logic signed [TW:0] dy_s;
  logic [TW:0]        dx_m;
  logic [TW:0]        dy_m;
  logic [2:0]         bx_c;
  logic [2:0]         by_c;

  always_comb begin
    dx_s = $signed({1'b0, pt_x}) - $signed({1'b0, ot_x});
    dy_s = $signed({1'b0, pt_y}) - $signed({1'b0, ot_y});
    dx_m = (dx_s < 0) ? $unsigned(-dx_s) : $unsigned(dx_s);
    dy_m = (dy_s < 0) ? $unsigned(-dy_s) : $unsigned(dy_s);
    bx_c = (dx_m[TW:12] >= 19'(BIN_FAR)) ? BIN_FAR : dx_m[14:12];
    by_c = (dy_m[TW:12] >= 19'(BIN_FAR)) ? BIN_FAR : dy_m[14:12];
  end

  // weighted channel terms
  logic signed [WTW-1:0] w;
  logic signed [COLW-1:0] term [4];

  always_comb begin
    w = tap_weight(bin_x, bin_y);
    for (int k = 0; k < 4; k++) begin
      term[k] = COLW'($signed({1'b0, pix[8*k +: 8]}) * w);
    end
  end

  // channel finish: special cases and divider operands
  logic signed [COLW-1:0] c_sel;
  logic [COLW-1:0]        mc;
  logic [TOTW-1:0]        mt;
  logic                   fin_direct;
  logic [7:0]             fin_q;
  logic [COLW-1:0]        trial;
  logic                   last_tap;

  always_comb begin
    c_sel      = col[ch];
    mc         = (c_sel < 0) ? $unsigned(-c_sel) : $unsigned(c_sel);
    mt         = (total < 0) ? $unsigned(-total) : $unsigned(total);
    fin_direct = 1'b1;
    fin_q      = 8'd0;
    if (total == '0) begin
      if (c_sel > 0) begin
        fin_q = (mc[COLW-1:14] > 22'd255) ? 8'd255 : mc[21:14];
      end
    end else if (c_sel == '0 || ((c_sel < 0) != (total < 0))) begin
      fin_q = 8'd0;
    end else if (mc >= {2'b0, mt, 8'b0}) begin
      fin_q = 8'd255;
    end else begin
      fin_direct = 1'b0;
    end
    trial    = COLW'({mt, 8'b0} >> (3'd7 - step)) >> 1;
    last_tap = (px == hi_x) && (py == hi_y);
  end

  // queue and frame store hooks
  assign q_take    = (state == ST_IDLE) && q_valid && (q_item.is_load || !res_valid);
  assign mem_we    = (state == ST_IDLE) && q_valid && q_item.is_load && q_item.load_ok;
  assign mem_waddr = AW'(q_item.y * MAX_WIDTH + q_item.x);
  assign mem_wdata = q_item.pix;
  assign mem_raddr = AW'(py * MAX_WIDTH + px);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_take && !q_item.is_load) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= ST_WIN;
        end
        ST_WIN: begin
          if (oor_c) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (a_x > bc_x || a_y > bc_y) begin
            state <= ST_DIV_INIT;
          end else begin
            state <= ST_TAP_A;
          end
        end
        ST_TAP_A: state <= ST_TAP_B;
        ST_TAP_B: state <= ST_TAP_C;
        ST_TAP_C: begin
          state <= last_tap ? ST_DIV_INIT : ST_TAP_A;
        end
        ST_DIV_INIT: begin
          if (fin_direct) begin
            if (ch == 2'd3) begin
              res_valid <= 1'b1;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_DIV_STEP;
          end
        end
        ST_DIV_STEP: begin
          if (step == 3'd0) begin
            if (ch == 2'd3) begin
              res_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_DIV_INIT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req_x <= q_item.x;
        req_y <= q_item.y;
        up    <= up_c;
        dw_p  <= sw * sf;
        dh_p  <= sh * sf;
        c_x   <= TW'(ox2 * inv);
        c_y   <= TW'(oy2 * inv);
        m1_x  <= TW'(ox5 * inv);
        m1_y  <= TW'(oy5 * inv);
        m2_x  <= TW'(ox7 * inv);
        m2_y  <= TW'(oy7 * inv);
        ch    <= 2'd0;
        total <= '0;
        for (int k = 0; k < 4; k++) begin
          col[k] <= '0;
        end
      end
      ST_SETUP: begin
        ot_x <= up ? c_x : TW'({ox2_r(req_x), 12'b0});
        ot_y <= up ? c_y : TW'({ox2_r(req_y), 12'b0});
      end
      ST_WIN: begin
        res_oor <= oor_c;
        lo_x    <= a_x;
        hi_x    <= bc_x;
        hi_y    <= bc_y;
        px      <= a_x;
        py      <= a_y;
        for (int k = 0; k < 4; k++) begin
          chan_q[k] <= 8'd0;
        end
      end
      ST_TAP_A: begin
        pt_x <= up ? TW'({px, 1'b1, 12'b0}) : TW'({px, 1'b1} * sf);
        pt_y <= up ? TW'({py, 1'b1, 12'b0}) : TW'({py, 1'b1} * sf);
      end
      ST_TAP_B: begin
        bin_x <= bx_c;
        bin_y <= by_c;
        pix   <= mem_rdata;
      end
      ST_TAP_C: begin
        for (int k = 0; k < 4; k++) begin
          col[k] <= col[k] + term[k];
        end
        total <= total + TOTW'(w);
        if (px == hi_x) begin
          px <= lo_x;
          py <= py + PW'(1);
        end else begin
          px <= px + PW'(1);
        end
      end
      ST_DIV_INIT: begin
        rem  <= mc;
        quo  <= 8'd0;
        step <= 3'd7;
        if (fin_direct) begin
          chan_q[ch] <= fin_q;
          ch         <= ch + 2'd1;
        end
      end
      ST_DIV_STEP: begin
        if (rem >= trial) begin
          rem <= rem - trial;
        end
        quo[step] <= (rem >= trial);
        step      <= step - 3'd1;
        if (step == 3'd0) begin
          chan_q[ch] <= {quo[7:1], rem >= trial};
          ch         <= ch + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign empty        = !res_valid;
  assign out_of_range = res_oor;
  assign red_out      = res_oor ? 8'd0 : chan_q[0];
  assign green_out    = res_oor ? 8'd0 : chan_q[1];
  assign blue_out     = res_oor ? 8'd0 : chan_q[2];
  assign alpha_out    = res_oor ? 8'd0 : chan_q[3];

  // a request only starts with the result slot free
  a_req_slot: assert property (@(posedge clk) disable iff (rst)
    (q_take && !q_item.is_load) |-> !res_valid)
    else $error("request started while result pending");

  // the tap walk stays inside the clipped window
  a_tap_in_win: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAP_A) |-> (px <= hi_x && py <= hi_y))
    else $error("tap outside window");

  // a result appears only from the window check or the divider
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_WIN || $past(state) == ST_DIV_INIT ||
                          $past(state) == ST_DIV_STEP))
    else $error("result raised from wrong state");

endmodule

>>> hdl/lanczos3_image_resizer.sv
// ----------------------------------------------------------------------------
// lanczos3_image_resizer
// lanczos-3 resampler over a source frame store, apb configuration
// ----------------------------------------------------------------------------
// loads: a load beat is queued, then written to the store when the execution side is idle
// request: out of range ends at the window check, else each window tap goes through
//   store read, bin and mac in turn, then the divider finishes the four channels
// throughput: one load a cycle when idle; a request starts once the previous result is popped
// reset (rst, synchronous) empties the queue and result slot, restores the registers
// the frame store is not cleared: unwritten pixels read as anything
module lanczos3_image_resizer import lzr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [9:0]  coord_x,
  input  logic [9:0]  coord_y,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out,
  output logic        out_of_range
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t cfg;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= RST_SRC_WIDTH;
      cfg.src_height <= RST_SRC_HEIGHT;
      cfg.scale      <= RST_SCALE;
      cfg.inv_scale  <= RST_INV_SCALE;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SRC_WIDTH:  cfg.src_width  <= pwdata[8:0];
        REG_SRC_HEIGHT: cfg.src_height <= pwdata[8:0];
        REG_SCALE:      cfg.scale      <= pwdata[14:0];
        REG_INV_SCALE:  cfg.inv_scale  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_SRC_WIDTH:  prdata = {23'b0, cfg.src_width};
      REG_SRC_HEIGHT: prdata = {23'b0, cfg.src_height};
      REG_SCALE:      prdata = {17'b0, cfg.scale};
      REG_INV_SCALE:  prdata = {17'b0, cfg.inv_scale};
      default:        prdata = '0;
    endcase
  end

  logic          q_valid;
  fe_item_t      q_item;
  logic          q_take;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // input side
  lzr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .kind     (kind),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .alpha_in (alpha_in),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  // source frame store
  lzr_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // execution side
  lzr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_take       (q_take),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .pop          (pop),
    .empty        (empty),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .alpha_out    (alpha_out),
    .out_of_range (out_of_range)
  );

endmodule
